/* rtl/core/cfcc_pkg.sv */
`timescale 1ns / 1ps

package cfcc_pkg;

	localparam int unsigned DataW  = 32;
	localparam int unsigned CountW = $clog2(DataW);
	localparam int unsigned IndexW = 2;
	localparam int unsigned ClassW = 2;

	localparam logic [DataW-1:0] ClockHzReset    = 32'd72000000;
	localparam logic [DataW-1:0] RedLimitReset   = 32'd15000;
	localparam logic [DataW-1:0] GreenLimitReset = 32'd25000;

	typedef enum logic [IndexW-1:0] {
		REG_CLOCK_HZ    = 2'd0,
		REG_RED_LIMIT   = 2'd1,
		REG_GREEN_LIMIT = 2'd2
	} reg_index_t;

	typedef enum logic [ClassW-1:0] {
		COLOR_RED   = 2'd0,
		COLOR_GREEN = 2'd1,
		COLOR_BLUE  = 2'd2
	} color_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic period_zero;
		logic out_free;
	} sts_t;

endpackage

/* rtl/core/capture_frequency_color_classifier.sv */
`timescale 1ns / 1ps

// capture frequency color classifier: each input word is a timer capture
// value; the block returns one output word per input holding the period
// (difference from the previous capture, modulo 2^32), the held frequency
// clock_hz / period, its color class (0 red, 1 green, 2 blue by the two
// limits) and a flag that marks a zero period, where the frequency is kept.
// an item is accepted, the bit-serial restoring divider makes one quotient
// bit per step, the finish writes the result; a zero period has no steps.
// the next word is taken in the cycle after the finish. the output register
// lets the next capture be taken and divided while a result still waits.
// configuration: cfg_we with cfg_index 0 clock_hz, 1 red_limit,
// 2 green_limit; index 3 is ignored. write only while idle.

module capture_frequency_color_classifier (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write port
	input  logic                        cfg_we,
	input  logic [cfcc_pkg::IndexW-1:0] cfg_index,
	input  logic [cfcc_pkg::DataW-1:0]  cfg_data,
	// capture input
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [cfcc_pkg::DataW-1:0]  capture_value,
	// result output
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [cfcc_pkg::DataW-1:0]  period_ticks,
	output logic [cfcc_pkg::DataW-1:0]  frequency_hz,
	output logic [cfcc_pkg::ClassW-1:0] color_class,
	output logic                        period_zero
);
	import cfcc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: idle, divide, finish
	cfcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// config registers, capture state, divider and output register
	cfcc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.capture_value (capture_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.period_ticks  (period_ticks),
		.frequency_hz  (frequency_hz),
		.color_class   (color_class),
		.period_zero   (period_zero)
	);

	// a taken capture keeps the input closed while it is worked on
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input open right after accepting a capture");

	// a new result only appears at the end of an item's work
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in work");

	// the class code is never the unused value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (color_class <= COLOR_BLUE))
		else $error("invalid color class");

	// a zero period leaves the shown frequency where the last result had it
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && sts.period_zero && out_valid) |=> $stable(frequency_hz))
		else $error("frequency changed on a zero period");

endmodule

/* rtl/core/cfcc_ctrl.sv */
`timescale 1ns / 1ps

module cfcc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  cfcc_pkg::sts_t sts,
	output cfcc_pkg::cmd_t cmd
);
	import cfcc_pkg::*;

	state_t            state_q;
	state_t            state_d;
	logic [CountW-1:0] cnt_q;
	logic [CountW-1:0] cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		cmd        = '0;
		in_stall   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				// zero period skips the quotient entirely
				if (sts.period_zero) begin
					state_d = ST_FINISH;
				end else begin
					cmd.step = 1'b1;
					cnt_d    = cnt_q + 1'b1;
					if (cnt_q == CountW'(DataW - 1)) begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/cfcc_dp.sv */
`timescale 1ns / 1ps

module cfcc_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfcc_pkg::cmd_t              cmd,
	output cfcc_pkg::sts_t              sts,
	input  logic                        cfg_we,
	input  logic [cfcc_pkg::IndexW-1:0] cfg_index,
	input  logic [cfcc_pkg::DataW-1:0]  cfg_data,
	input  logic [cfcc_pkg::DataW-1:0]  capture_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [cfcc_pkg::DataW-1:0]  period_ticks,
	output logic [cfcc_pkg::DataW-1:0]  frequency_hz,
	output logic [cfcc_pkg::ClassW-1:0] color_class,
	output logic                        period_zero
);
	import cfcc_pkg::*;

	logic [DataW-1:0] clock_hz_q;
	logic [DataW-1:0] red_limit_q;
	logic [DataW-1:0] green_limit_q;
	logic [DataW-1:0] prev_cap_q;
	logic [DataW-1:0] held_freq_q;
	logic [DataW-1:0] period_q;
	logic [DataW-1:0] quo_q;
	logic [DataW-1:0] rem_q;
	logic             out_valid_q;
	logic [DataW-1:0] period_out_q;
	logic [DataW-1:0] freq_out_q;
	color_t           class_out_q;
	logic             zero_out_q;

	logic [DataW:0]   shifted;
	logic [DataW+1:0] diff;
	logic             neg;
	logic             zero_now;
	logic [DataW-1:0] new_freq;
	color_t           new_class;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q    <= ClockHzReset;
			red_limit_q   <= RedLimitReset;
			green_limit_q <= GreenLimitReset;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CLOCK_HZ:    clock_hz_q    <= cfg_data;
				REG_RED_LIMIT:   red_limit_q   <= cfg_data;
				REG_GREEN_LIMIT: green_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// restoring divider, one quotient bit per step
	assign shifted = {rem_q, quo_q[DataW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, period_q};
	assign neg     = diff[DataW+1];

	assign zero_now = (period_q == '0);
	assign new_freq = zero_now ? held_freq_q : quo_q;

	always_comb begin
		if (new_freq < red_limit_q) begin
			new_class = COLOR_RED;
		end else if (new_freq < green_limit_q) begin
			new_class = COLOR_GREEN;
		end else begin
			new_class = COLOR_BLUE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			period_q <= capture_value - prev_cap_q;
			quo_q    <= clock_hz_q;
			rem_q    <= '0;
		end else if (cmd.step) begin
			quo_q <= {quo_q[DataW-2:0], ~neg};
			rem_q <= neg ? shifted[DataW-1:0] : diff[DataW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_cap_q  <= '0;
			held_freq_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				prev_cap_q <= capture_value;
			end
			if (cmd.finish) begin
				held_freq_q <= new_freq;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			period_out_q <= period_q;
			freq_out_q   <= new_freq;
			class_out_q  <= new_class;
			zero_out_q   <= zero_now;
		end
	end

	assign sts.period_zero = zero_now;
	assign sts.out_free    = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign period_ticks = period_out_q;
	assign frequency_hz = freq_out_q;
	assign color_class  = class_out_q;
	assign period_zero  = zero_out_q;

endmodule
